@@ hw/rtl/sstf_pkg.sv @@
// Shared types and constants for the SSTF disk request scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package sstf_pkg;

    localparam int FIELD_BITS = 16;
    localparam int SUM_BITS   = 22;

    localparam logic [FIELD_BITS-1:0] DIST_MAX = 16'hFFFF;
    localparam logic [SUM_BITS-1:0]   SUM_MAX  = 22'h3FFFFF;

    typedef struct packed {
        logic [FIELD_BITS-1:0] track;
        logic                  last;
    } req_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] served_track;
        logic [FIELD_BITS-1:0] seek_distance;
        logic [SUM_BITS-1:0]   total_movement;
        logic                  overflow;
        logic                  final_res;
    } res_out_t;

    typedef struct packed {
        logic load;
        logic serve;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } sched_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sstf_cell.sv @@
// One request slot of the scheduler chain: holds a track and its served bit,
// and passes the nearest-so-far candidate to its neighbor every cycle.
// Depends on sstf_pkg.
`default_nettype none

module sstf_cell
    import sstf_pkg::*;
#(
    parameter int TRACK_BITS = 16,
    parameter int IDX_BITS   = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [TRACK_BITS-1:0] head,
    input  wire logic [TRACK_BITS-1:0] load_track,
    input  wire logic                  in_found,
    input  wire logic [TRACK_BITS-1:0] in_dist,
    input  wire logic [TRACK_BITS-1:0] in_track,
    input  wire logic [IDX_BITS-1:0]   in_idx,
    output logic                       out_found,
    output logic [TRACK_BITS-1:0]      out_dist,
    output logic [TRACK_BITS-1:0]      out_track,
    output logic [IDX_BITS-1:0]        out_idx
);

    logic [TRACK_BITS-1:0] track_reg;
    logic                  valid_reg;
    logic                  served_reg;
    logic                  found_reg;
    logic [TRACK_BITS-1:0] dist_reg;
    logic [TRACK_BITS-1:0] cand_track_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    logic [TRACK_BITS-1:0] own_dist;
    logic                  own_live;
    logic                  take_own;

    assign own_dist = (head >= track_reg) ? (head - track_reg) : (track_reg - head);
    assign own_live = valid_reg && !served_reg;
    // earlier cells win ties: replace only on strictly smaller distance
    assign take_own = own_live && (!in_found || (own_dist < in_dist));

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            track_reg <= load_track;
        end
        dist_reg       <= take_own ? own_dist : in_dist;
        cand_track_reg <= take_own ? track_reg : in_track;
        idx_reg        <= take_own ? IDX_BITS'(INDEX) : in_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            served_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            found_reg <= take_own || in_found;
            if (ctrl.clear)
            begin
                valid_reg  <= 1'b0;
                served_reg <= 1'b0;
            end
            else if (ctrl.load)
            begin
                valid_reg  <= 1'b1;
                served_reg <= 1'b0;
            end
            else if (ctrl.serve)
            begin
                served_reg <= 1'b1;
            end
        end
    end

    assign out_found = found_reg;
    assign out_dist  = dist_reg;
    assign out_track = cand_track_reg;
    assign out_idx   = idx_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sstf_disk_request_scheduler.sv @@
// Shortest-seek-time-first scheduler top level: load control, run sequencer
// and result register around a chain of sstf_cell slots. Depends on sstf_pkg.
//
// Requests are loaded one per cycle while busy is low; the item with last set
// is stored and starts a run from head_start. Each selection lets the nearest
// candidate travel the full chain before it is served; busy stays high until
// the final result of the run. Each result shows on result for exactly one
// cycle with done high; it must be taken then, there is no backpressure.
`default_nettype none

module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_in_t               req,
    input  wire logic                  cfg_wr_en,
    input  wire logic [FIELD_BITS-1:0] cfg_wr_data,
    output logic                       done,
    output res_out_t                   result
);

    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);

    sched_state_t state_reg, state_next;

    logic [FIELD_BITS-1:0] head_start_reg;
    logic [TRACK_BITS-1:0] head_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         served_cnt_reg;
    logic [CW-1:0]         scan_cnt_reg;
    logic                  dropped_reg;
    logic                  done_reg;
    res_out_t              result_reg;

    logic accept;
    logic room;
    logic emit;
    logic last_one;

    logic                  ch_found [MAX_REQUESTS+1];
    logic [TRACK_BITS-1:0] ch_dist  [MAX_REQUESTS+1];
    logic [TRACK_BITS-1:0] ch_track [MAX_REQUESTS+1];
    logic [IW-1:0]         ch_idx   [MAX_REQUESTS+1];
    cell_ctrl_t            cell_ctrl [MAX_REQUESTS];

    logic [TRACK_BITS-1:0] load_track;
    logic [32:0]           dist_ext;
    logic [33:0]           sum_ext;
    logic [SUM_BITS-1:0]   sum_sat;
    logic [FIELD_BITS-1:0] dist_sat;

    assign accept     = start && !busy;
    assign room       = (count_reg < CW'(MAX_REQUESTS));
    assign load_track = TRACK_BITS'(req.track);
    assign emit       = (state_reg == ST_SCAN) && (scan_cnt_reg == CW'(MAX_REQUESTS));
    assign last_one   = ((served_cnt_reg + CW'(1)) == count_reg) || !ch_found[MAX_REQUESTS];

    assign dist_ext = 33'(ch_dist[MAX_REQUESTS]);
    assign sum_ext  = 34'(sum_reg) + 34'(ch_dist[MAX_REQUESTS]);
    assign sum_sat  = (sum_ext > 34'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_BITS-1:0];
    assign dist_sat = (dist_ext > 33'(DIST_MAX)) ? DIST_MAX : dist_ext[FIELD_BITS-1:0];

    assign ch_found[0] = 1'b0;
    assign ch_dist[0]  = '0;
    assign ch_track[0] = '0;
    assign ch_idx[0]   = '0;

    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_cell
        assign cell_ctrl[i].load  = accept && room && (count_reg == CW'(i));
        assign cell_ctrl[i].serve = emit && ch_found[MAX_REQUESTS]
                                    && (ch_idx[MAX_REQUESTS] == IW'(i));
        assign cell_ctrl[i].clear = emit && last_one;

        sstf_cell #(
            .TRACK_BITS (TRACK_BITS),
            .IDX_BITS   (IW),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .head       (head_reg),
            .load_track (load_track),
            .in_found   (ch_found[i]),
            .in_dist    (ch_dist[i]),
            .in_track   (ch_track[i]),
            .in_idx     (ch_idx[i]),
            .out_found  (ch_found[i+1]),
            .out_dist   (ch_dist[i+1]),
            .out_track  (ch_track[i+1]),
            .out_idx    (ch_idx[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (emit && last_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_start_reg <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            scan_cnt_reg   <= '0;
            dropped_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                head_start_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
                if (req.last)
                begin
                    head_reg       <= TRACK_BITS'(head_start_reg);
                    sum_reg        <= '0;
                    served_cnt_reg <= '0;
                    scan_cnt_reg   <= '0;
                end
            end
            if (state_reg == ST_SCAN)
            begin
                if (emit)
                begin
                    scan_cnt_reg   <= '0;
                    served_cnt_reg <= served_cnt_reg + CW'(1);
                    head_reg       <= ch_track[MAX_REQUESTS];
                    sum_reg        <= sum_sat;
                    done_reg       <= ch_found[MAX_REQUESTS];
                    if (last_one)
                    begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                end
                else
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.served_track   <= FIELD_BITS'(ch_track[MAX_REQUESTS]);
            result_reg.seek_distance  <= dist_sat;
            result_reg.total_movement <= sum_sat;
            result_reg.overflow       <= dropped_reg;
            result_reg.final_res      <= last_one;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sstf_checker.sv @@
// Port-level checks for the SSTF scheduler, bound to the top level.
// Depends on sstf_pkg.
`default_nettype none

module sstf_checker
    import sstf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire req_in_t               req,
    input wire logic                  done,
    input wire res_out_t              result
);

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without a run in progress");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.last) |=> busy)
        else $error("last request did not start a run");

    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.final_res) |-> !busy)
        else $error("busy still high after final result");

    a_nonfinal_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.final_res) |-> busy)
        else $error("run ended before final result");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_sstf_checker (.*);

`default_nettype wire

@@ bench/tb_sstf_disk_request_scheduler.sv @@
// Self-checking testbench for sstf_disk_request_scheduler: directed and random batches of
// track requests, with an in-bench SSTF predictor and an in-order result checker.
// Depends on sstf_pkg and the scheduler RTL only.
`default_nettype none

module tb_sstf_disk_request_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_pkg::*;

    localparam int MAX_REQ       = 32;
    localparam int SETTLE_CYCLES = MAX_REQ + 9;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    req_in_t               req = '0;
    logic                  cfg_wr_en = 1'b0;
    logic [FIELD_BITS-1:0] cfg_wr_data = '0;
    logic                  done;
    res_out_t              result;

    // scheduler model state
    logic [FIELD_BITS-1:0] pending_tracks[$];
    bit                    pending_dropped = 1'b0;
    logic [FIELD_BITS-1:0] head_start_cfg = '0;
    res_out_t              expected_services[$];

    logic [FIELD_BITS-1:0] batch_plan[$];
    int                    sender_idle_pct = 0;
    int                    requests_sent = 0;
    int                    mismatches = 0;
    int                    cycle_count = 0;

    sstf_disk_request_scheduler #(
        .MAX_REQUESTS(MAX_REQ),
        .TRACK_BITS  (FIELD_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .result     (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < MAX_REPORTS)
            $display("ERROR @%0t %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Store one request; on the last one, run the nearest-first service order.
    function automatic void predict_request(input req_in_t item);
        bit                    served[MAX_REQ];
        logic [FIELD_BITS-1:0] head;
        int unsigned           total;
        int unsigned           step_dist;
        int unsigned           best_dist;
        int                    best;
        int                    n;
        res_out_t              svc;
        if (pending_tracks.size() < MAX_REQ)
            pending_tracks.push_back(item.track);
        else
            pending_dropped = 1'b1;
        if (!item.last)
            return;
        n = pending_tracks.size();
        head = head_start_cfg;
        total = 0;
        foreach (served[i])
            served[i] = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            best = -1;
            best_dist = 0;
            for (int i = 0; i < n; i++)
            begin
                if (served[i])
                    continue;
                step_dist = (head >= pending_tracks[i]) ? head - pending_tracks[i]
                                                        : pending_tracks[i] - head;
                if (best < 0 || step_dist < best_dist)
                begin
                    best = i;
                    best_dist = step_dist;
                end
            end
            served[best] = 1'b1;
            total = (total + best_dist > SUM_MAX) ? SUM_MAX : total + best_dist;
            head = pending_tracks[best];
            svc.served_track   = head;
            svc.seek_distance  = (best_dist > DIST_MAX) ? DIST_MAX : 16'(best_dist);
            svc.total_movement = 22'(total);
            svc.overflow       = pending_dropped;
            svc.final_res      = (k == n - 1);
            expected_services.push_back(svc);
        end
        pending_tracks.delete();
        pending_dropped = 1'b0;
    endfunction

    always @(posedge clk)
    begin : check_results
        res_out_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_services.size() == 0)
                report_mismatch("unexpected result, served_track", result.served_track, 0);
            else
            begin
                want = expected_services.pop_front();
                if (result.served_track !== want.served_track)
                    report_mismatch("served_track", result.served_track, want.served_track);
                if (result.seek_distance !== want.seek_distance)
                    report_mismatch("seek_distance", result.seek_distance,
                                    want.seek_distance);
                if (result.total_movement !== want.total_movement)
                    report_mismatch("total_movement", result.total_movement,
                                    want.total_movement);
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", result.overflow, want.overflow);
                if (result.final_res !== want.final_res)
                    report_mismatch("final_res", result.final_res, want.final_res);
            end
        end
    end

    // One request transfer; start stays high afterwards until the next call or a drain.
    task automatic send_request(input logic [FIELD_BITS-1:0] trk, input logic lst);
        req_in_t item;
        item.track = trk;
        item.last  = lst;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(item);
        requests_sent++;
    endtask

    task automatic send_planned_batch();
        foreach (batch_plan[i])
            send_request(batch_plan[i], i == batch_plan.size() - 1);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_services.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_head_start(input logic [FIELD_BITS-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        head_start_cfg = value;
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_head();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return FIELD_BITS'($urandom_range(16'hFFFF));
    endfunction

    // Mix of uniform tracks, tight clusters (equal distances), extremes and repeats.
    function automatic logic [FIELD_BITS-1:0] pick_track(input logic [FIELD_BITS-1:0] center);
        int m;
        m = $urandom_range(9);
        if (m < 3)
            return FIELD_BITS'($urandom_range(16'hFFFF));
        if (m < 7)
            return center + FIELD_BITS'($urandom_range(16)) - FIELD_BITS'(8);
        if (m == 7 || batch_plan.size() == 0)
            return $urandom_range(1) ? '1 : '0;
        return batch_plan[$urandom_range(batch_plan.size() - 1)];
    endfunction

    task automatic test_reset_head();
        batch_plan = '{16'd5};
        send_planned_batch();
        drain_results();
    endtask

    task automatic test_head_extremes();
        write_head_start('0);
        batch_plan = '{16'hFFFF};
        send_planned_batch();
        write_head_start('1);
        batch_plan = '{16'h0000, 16'hFFFF};
        send_planned_batch();
        drain_results();
    endtask

    task automatic test_tie_break();
        write_head_start(16'd1000);
        batch_plan = '{16'd1010, 16'd990, 16'd1010, 16'd990};
        send_planned_batch();
        drain_results();
    endtask

    task automatic test_nearest_order();
        write_head_start(16'd30000);
        batch_plan = '{16'd0, 16'd65535, 16'd29000, 16'd31500, 16'd30000};
        send_planned_batch();
        drain_results();
    endtask

    task automatic test_bit_patterns();
        write_head_start(16'h8000);
        batch_plan = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000};
        send_planned_batch();
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int budget);
        int                    goal;
        int                    n;
        int                    r;
        bit                    first;
        logic [FIELD_BITS-1:0] center;
        sender_idle_pct = idle_pct;
        goal = requests_sent + budget;
        first = 1'b1;
        write_head_start(pick_head());
        while (requests_sent < goal)
        begin
            if (!first && $urandom_range(5) == 0)
            begin
                if ($urandom_range(1))
                    write_head_start(pick_head());
                else
                    drain_results();
            end
            r = $urandom_range(99);
            if (first)
                n = MAX_REQ + 1 + $urandom_range(7);
            else if (r < 6)
                n = $urandom_range(MAX_REQ + 8, MAX_REQ - 2);
            else if (r < 16)
                n = 1;
            else
                n = $urandom_range(12, 2);
            center = $urandom_range(1) ? head_start_cfg : FIELD_BITS'($urandom_range(16'hFFFF));
            batch_plan.delete();
            for (int i = 0; i < n; i++)
                batch_plan.push_back(pick_track(center));
            send_planned_batch();
            first = 1'b0;
        end
        drain_results();
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_head();
        test_head_extremes();
        test_tie_break();
        test_nearest_order();
        test_bit_patterns();
        test_random_traffic(14, 160);
        test_random_traffic(71, 160);
        test_random_traffic(0, 160);
        drain_results();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_cell.sv
hw/rtl/sstf_disk_request_scheduler.sv
hw/rtl/sstf_checker.sv
bench/tb_sstf_disk_request_scheduler.sv
